// ===== rtl/esd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Shared request types, character codes and the control interface between
// the sequencing controller and the decoding datapath.
// ----------------------------------------------------------------------------
package esd_pkg;

    // One input request: a text character and the end-of-text flag.
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    // One output request: a decoded character and the terminator flag.
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // Character codes recognized by the decoder.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_O         = 8'h6F;
    localparam logic [7:0] CHAR_D         = 8'h64;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CODE_CR        = 8'h0D;
    localparam logic [7:0] CODE_LF        = 8'h0A;
    localparam logic [7:0] CODE_TAB       = 8'h09;
    localparam logic [7:0] CODE_NUL       = 8'h00;

    // Number of digit registers kept for a failed numeric escape.
    localparam int HELD_DEPTH = 7;

    // Output sequence of one input request. Each part is optional and the
    // parts always go out in this order: backslash, letter, held digits,
    // character, terminator.
    typedef struct packed {
        logic       bs;
        logic       letter;
        logic [2:0] held;
        logic       chr;
        logic       nul;
    } plan_t;

    // Source of the character loaded into the output register.
    typedef enum logic [2:0] {
        SRC_BS,
        SRC_LETTER,
        SRC_HELD,
        SRC_CHAR,
        SRC_NUL
    } src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
        src_t src;
        logic held_step;
    } esd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        plan_t plan_in;
        plan_t plan;
        logic  held_last;
        logic  out_free;
    } esd_stat_t;

endpackage
`default_nettype wire

// ===== rtl/esd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape sequence decoder datapath
// Holds the escape state, digit registers and accumulator, works out the
// output sequence of each request and drives the output register.
// ----------------------------------------------------------------------------
module esd_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire esd_pkg::in_item_t text,
    input  wire esd_pkg::esd_cmd_t cmd,
    output esd_pkg::esd_stat_t     stat,
    output esd_pkg::out_item_t     dec,
    output logic                   dec_valid,
    input  wire logic              dec_ready
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SLASH,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BIN,
        KIND_OCT,
        KIND_DEC,
        KIND_HEX
    } kind_t;

    // Value of a hex character in bits 3:0; bit 4 is set when it is a digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    // Escape letter that introduces each numeric kind.
    function automatic logic [7:0] kind_letter(input kind_t k);
        logic [7:0] l;
        unique case (k)
            KIND_BIN: l = esd_pkg::CHAR_B;
            KIND_OCT: l = esd_pkg::CHAR_O;
            KIND_DEC: l = esd_pkg::CHAR_D;
            KIND_HEX: l = esd_pkg::CHAR_X;
            default:  l = esd_pkg::CHAR_B;
        endcase
        return l;
    endfunction

    // Escape state.
    phase_t         phase_reg, phase_next;
    kind_t          kind_reg, kind_next;
    logic [2:0]     hc_reg, hc_next;
    logic [9:0]     acc_reg, acc_next;
    logic [7:0]     held_reg [esd_pkg::HELD_DEPTH];
    logic           held_we;

    // Registered output sequence of the current request.
    esd_pkg::plan_t plan_reg, plan_next;
    logic [7:0]     letter_reg, letter_next;
    logic [7:0]     char_reg, char_next;
    logic [2:0]     idx_reg;

    // Output register.
    esd_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    esd_pkg::out_item_t out_src;

    // Digit decode helpers.
    logic [7:0] c;
    logic       last;
    logic [4:0] hv;
    logic       digit_ok;
    logic       complete;
    logic [9:0] acc_scaled;
    logic [9:0] acc_new;
    logic       plain_slash;

    assign c           = text.in_char;
    assign last        = text.in_last;
    assign hv          = hex_value(c);
    assign plain_slash = (c == esd_pkg::CHAR_BACKSLASH) && !last;

    // Digit check against the base and the accumulator step (mod 1024).
    always_comb
    begin
        unique case (kind_reg)
            KIND_BIN:
            begin
                digit_ok   = hv[4] && (hv[3:1] == 3'd0);
                complete   = (hc_reg == 3'd7);
                acc_scaled = {acc_reg[8:0], 1'b0};
            end
            KIND_OCT:
            begin
                digit_ok   = hv[4] && !hv[3];
                complete   = (hc_reg >= 3'd2);
                acc_scaled = {acc_reg[6:0], 3'b000};
            end
            KIND_DEC:
            begin
                digit_ok   = hv[4] && (hv[3:0] < 4'd10);
                complete   = (hc_reg >= 3'd2);
                acc_scaled = {acc_reg[6:0], 3'b000} + {acc_reg[8:0], 1'b0};
            end
            KIND_HEX:
            begin
                digit_ok   = hv[4];
                complete   = (hc_reg >= 3'd1);
                acc_scaled = {acc_reg[5:0], 4'b0000};
            end
            default:
            begin
                digit_ok   = 1'b0;
                complete   = 1'b0;
                acc_scaled = '0;
            end
        endcase
        acc_new = acc_scaled + {6'd0, hv[3:0]};
    end

    // Next escape state and output sequence of the offered request.
    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        hc_next     = hc_reg;
        acc_next    = acc_reg;
        letter_next = letter_reg;
        char_next   = char_reg;
        held_we     = 1'b0;
        plan_next   = '0;

        unique case (phase_reg)
            PH_SLASH:
            begin
                phase_next    = PH_IDLE;
                plan_next.nul = last;
                unique case (c)
                    esd_pkg::CHAR_R:
                    begin
                        plan_next.chr = 1'b1;
                        char_next     = esd_pkg::CODE_CR;
                    end
                    esd_pkg::CHAR_N:
                    begin
                        plan_next.chr = 1'b1;
                        char_next     = esd_pkg::CODE_LF;
                    end
                    esd_pkg::CHAR_ZERO:
                    begin
                        plan_next.chr = 1'b1;
                        char_next     = esd_pkg::CODE_NUL;
                    end
                    esd_pkg::CHAR_T:
                    begin
                        plan_next.chr = 1'b1;
                        char_next     = esd_pkg::CODE_TAB;
                    end
                    esd_pkg::CHAR_BACKSLASH:
                    begin
                        plan_next.chr = 1'b1;
                        char_next     = esd_pkg::CHAR_BACKSLASH;
                    end
                    esd_pkg::CHAR_B, esd_pkg::CHAR_O, esd_pkg::CHAR_D, esd_pkg::CHAR_X:
                    begin
                        if (last)
                        begin
                            plan_next.bs     = 1'b1;
                            plan_next.letter = 1'b1;
                            letter_next      = c;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                            hc_next    = '0;
                            acc_next   = '0;
                            if (c == esd_pkg::CHAR_B)
                            begin
                                kind_next = KIND_BIN;
                            end
                            else if (c == esd_pkg::CHAR_O)
                            begin
                                kind_next = KIND_OCT;
                            end
                            else if (c == esd_pkg::CHAR_D)
                            begin
                                kind_next = KIND_DEC;
                            end
                            else
                            begin
                                kind_next = KIND_HEX;
                            end
                        end
                    end
                    default:
                    begin
                        // Unknown escape passes through literally.
                        plan_next.bs     = 1'b1;
                        plan_next.letter = 1'b1;
                        letter_next      = c;
                    end
                endcase
            end
            PH_DIGITS:
            begin
                if (!digit_ok)
                begin
                    // Failed escape: replay it, then treat the byte as plain text.
                    plan_next.bs     = 1'b1;
                    plan_next.letter = 1'b1;
                    plan_next.held   = hc_reg;
                    letter_next      = kind_letter(kind_reg);
                    hc_next          = '0;
                    acc_next         = '0;
                    phase_next       = plain_slash ? PH_SLASH : PH_IDLE;
                    plan_next.chr    = !plain_slash;
                    plan_next.nul    = last;
                    char_next        = c;
                end
                else if (complete)
                begin
                    plan_next.chr = 1'b1;
                    plan_next.nul = last;
                    char_next     = acc_new[7:0];
                    hc_next       = '0;
                    acc_next      = '0;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    held_we  = 1'b1;
                    hc_next  = hc_reg + 3'd1;
                    acc_next = acc_new;
                    if (last)
                    begin
                        // Text ends inside the digits: replay everything.
                        plan_next.bs     = 1'b1;
                        plan_next.letter = 1'b1;
                        plan_next.held   = hc_reg + 3'd1;
                        plan_next.nul    = 1'b1;
                        letter_next      = kind_letter(kind_reg);
                        hc_next          = '0;
                        acc_next         = '0;
                        phase_next       = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next    = plain_slash ? PH_SLASH : PH_IDLE;
                plan_next.chr = !plain_slash;
                plan_next.nul = last;
                char_next     = c;
            end
        endcase
    end

    // Control state of the escape decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_BIN;
            hc_reg    <= '0;
            acc_reg   <= '0;
            plan_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                hc_reg    <= hc_next;
                acc_reg   <= acc_next;
                plan_reg  <= plan_next;
                idx_reg   <= '0;
            end
            else if (cmd.held_step)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // Payload registers: digits, letter and character to emit.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            letter_reg <= letter_next;
            char_reg   <= char_next;
            if (held_we)
            begin
                held_reg[hc_reg] <= c;
            end
        end
    end

    // Select the character for the output register.
    always_comb
    begin
        unique case (cmd.src)
            esd_pkg::SRC_BS:     out_src = '{out_char: esd_pkg::CHAR_BACKSLASH, out_last: 1'b0};
            esd_pkg::SRC_LETTER: out_src = '{out_char: letter_reg, out_last: 1'b0};
            esd_pkg::SRC_HELD:   out_src = '{out_char: held_reg[idx_reg], out_last: 1'b0};
            esd_pkg::SRC_CHAR:   out_src = '{out_char: char_reg, out_last: 1'b0};
            esd_pkg::SRC_NUL:    out_src = '{out_char: esd_pkg::CODE_NUL, out_last: 1'b1};
            default:             out_src = '{out_char: esd_pkg::CODE_NUL, out_last: 1'b0};
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dec_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= out_src;
        end
    end

    assign dec       = out_reg;
    assign dec_valid = out_valid_reg;

    // Status for the controller.
    assign stat.plan_in   = plan_next;
    assign stat.plan      = plan_reg;
    assign stat.held_last = (idx_reg == (plan_reg.held - 3'd1));
    assign stat.out_free  = !out_valid_reg || dec_ready;

endmodule
`default_nettype wire

// ===== rtl/esd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape sequence decoder controller
// Accepts one request at a time and walks its output sequence, one result
// per cycle whenever the output register is free.
// ----------------------------------------------------------------------------
module esd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               text_valid,
    output logic                    text_ready,
    input  wire esd_pkg::esd_stat_t stat,
    output esd_pkg::esd_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS,
        ST_LETTER,
        ST_HELD,
        ST_CHAR,
        ST_NUL
    } state_t;

    // Position of each part in the output sequence.
    localparam logic [2:0] RANK_BS     = 3'd0;
    localparam logic [2:0] RANK_LETTER = 3'd1;
    localparam logic [2:0] RANK_HELD   = 3'd2;
    localparam logic [2:0] RANK_CHAR   = 3'd3;
    localparam logic [2:0] RANK_NUL    = 3'd4;

    // First part of the sequence at or after the given position.
    function automatic state_t first_from(input esd_pkg::plan_t p, input logic [2:0] rank);
        state_t s;
        priority if (rank <= RANK_BS && p.bs)
        begin
            s = ST_BS;
        end
        else if (rank <= RANK_LETTER && p.letter)
        begin
            s = ST_LETTER;
        end
        else if (rank <= RANK_HELD && p.held != 3'd0)
        begin
            s = ST_HELD;
        end
        else if (rank <= RANK_CHAR && p.chr)
        begin
            s = ST_CHAR;
        end
        else if (rank <= RANK_NUL && p.nul)
        begin
            s = ST_NUL;
        end
        else
        begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    state_t state_reg, state_next;
    logic   ready_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.src       = esd_pkg::SRC_BS;
        cmd.held_step = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (text_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = first_from(stat.plan_in, RANK_BS);
                end
            end
            ST_BS:
            begin
                cmd.src = esd_pkg::SRC_BS;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = first_from(stat.plan, RANK_LETTER);
                end
            end
            ST_LETTER:
            begin
                cmd.src = esd_pkg::SRC_LETTER;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = first_from(stat.plan, RANK_HELD);
                end
            end
            ST_HELD:
            begin
                cmd.src = esd_pkg::SRC_HELD;
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.held_last)
                    begin
                        state_next = first_from(stat.plan, RANK_CHAR);
                    end
                    else
                    begin
                        cmd.held_step = 1'b1;
                    end
                end
            end
            ST_CHAR:
            begin
                cmd.src = esd_pkg::SRC_CHAR;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = first_from(stat.plan, RANK_NUL);
                end
            end
            ST_NUL:
            begin
                cmd.src = esd_pkg::SRC_NUL;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign text_ready = ready_reg;

endmodule
`default_nettype wire

// ===== rtl/escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Decodes backslash escapes in a character stream and appends a terminating
// NUL after the last character of each text.
// ----------------------------------------------------------------------------
// Usage:
//   The text channel (text_valid, text_ready, text) takes one character per
//   request, with in_last set on the final character of a text. The dec
//   channel (dec_valid, dec_ready, dec) returns decoded characters; the
//   appended NUL carries out_last.
//   One request is worked on at a time. A request is first loaded into the
//   sequence registers; its results then go out one by one through the
//   output register while the receiver keeps dec_ready high. A request
//   yields none for a backslash, a letter opening a numeric escape, or a
//   digit inside one, and at most 11 results, when a failed binary escape
//   is replayed together with the breaking character and NUL.
//   The throughput is set by the controller walking the output sequence
//   through the single output register.
//   After reset the decoder is idle with no escape pending; text_ready is
//   registered and rises after reset is released.
//   When the receiver stalls, the pending result stays in the output
//   register and the controller waits; no result is lost or repeated.
// ----------------------------------------------------------------------------
module escape_sequence_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              text_valid,
    output logic                   text_ready,
    input  wire esd_pkg::in_item_t text,
    output logic                   dec_valid,
    input  wire logic              dec_ready,
    output esd_pkg::out_item_t     dec
);

    esd_pkg::esd_cmd_t  cmd;
    esd_pkg::esd_stat_t stat;

    // Sequencing controller.
    esd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Decoding datapath with the output register.
    esd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cmd       (cmd),
        .stat      (stat),
        .dec       (dec),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready)
    );

endmodule
`default_nettype wire

// ===== rtl/esd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape sequence decoder checker
// Port-level checks of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module esd_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               text_valid,
    input  wire logic               text_ready,
    input  wire esd_pkg::in_item_t  text,
    input  wire logic               dec_valid,
    input  wire logic               dec_ready,
    input  wire esd_pkg::out_item_t dec
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid)
        else $error("result dropped while stalled");

    // The terminator flag only ever marks a NUL character.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec.out_last |-> dec.out_char == esd_pkg::CODE_NUL)
        else $error("terminator flag on a non-NUL character");

    // The final character always produces at least the NUL, so the decoder
    // must be busy right after accepting it.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text.in_last |=> !text_ready)
        else $error("decoder idle right after the final character");

    // A new result is produced only while the decoder is busy with a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dec_valid) |-> !$past(text_ready))
        else $error("result appeared while the decoder was idle");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec        (dec)
);
`default_nettype wire

// ===== sim/tb_escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Sends texts through the text channel and checks every decoded character
// against a cycle-free software decoder kept inside this bench. The run has
// a directed part, a back-pressure part and random texts under several
// sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder;

    // Kinds of numeric escape.
    typedef enum logic [1:0] {
        KIND_BIN,
        KIND_OCT,
        KIND_DEC,
        KIND_HEX
    } num_kind_t;

    // Decoder states of the software decoder.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLASH,
        ST_DIGITS
    } esc_state_t;

    // Character codes for the digit ranges.
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_F = 8'h66;
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_F = 8'h46;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               text_valid = 1'b0;
    logic               text_ready;
    esd_pkg::in_item_t  text       = '0;
    logic               dec_valid;
    logic               dec_ready  = 1'b0;
    esd_pkg::out_item_t dec;

    // Requests waiting to be sent and decoded characters still to arrive.
    esd_pkg::in_item_t  pending_text[$];
    esd_pkg::out_item_t expected_dec[$];
    logic [7:0]         text_buf[$];

    // Software decoder state.
    esc_state_t  esc_state  = ST_IDLE;
    num_kind_t   num_kind   = KIND_BIN;
    logic [7:0]  held_chars [7];
    logic [2:0]  held_n     = '0;
    logic [9:0]  acc_value  = '0;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left;
    bit hold_start      = 1'b0;
    int err_cnt         = 0;
    int accepted_cnt    = 0;
    int checked_cnt     = 0;
    int queued_cnt      = 0;
    int cycle_cnt       = 0;

    escape_sequence_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_valid(text_valid),
        .text_ready(text_ready),
        .text      (text),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec)
    );

    always #10 clk = ~clk;

    // Per-kind properties of numeric escapes.
    function automatic int radix(input num_kind_t k);
        case (k)
            KIND_BIN: return 2;
            KIND_OCT: return 8;
            KIND_DEC: return 10;
            default:  return 16;
        endcase
    endfunction

    function automatic int ndigits(input num_kind_t k);
        case (k)
            KIND_BIN: return 8;
            KIND_OCT: return 3;
            KIND_DEC: return 3;
            default:  return 2;
        endcase
    endfunction

    function automatic logic [7:0] kind_letter(input num_kind_t k);
        case (k)
            KIND_BIN: return esd_pkg::CHAR_B;
            KIND_OCT: return esd_pkg::CHAR_O;
            KIND_DEC: return esd_pkg::CHAR_D;
            default:  return esd_pkg::CHAR_X;
        endcase
    endfunction

    function automatic num_kind_t letter_kind(input logic [7:0] c);
        case (c)
            esd_pkg::CHAR_B: return KIND_BIN;
            esd_pkg::CHAR_O: return KIND_OCT;
            esd_pkg::CHAR_D: return KIND_DEC;
            default:         return KIND_HEX;
        endcase
    endfunction

    // Digit value in the given base, or -1 when the character is no digit.
    function automatic int digit_val(input logic [7:0] c, input int base);
        int v;
        if (c >= esd_pkg::CHAR_ZERO && c <= CHAR_NINE)
            v = int'(c) - int'(esd_pkg::CHAR_ZERO);
        else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
            v = int'(c) - int'(CHAR_LO_A) + 10;
        else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            v = int'(c) - int'(CHAR_UP_A) + 10;
        else
            return -1;
        if (v >= base)
            return -1;
        return v;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        case (c)
            esd_pkg::CHAR_R, esd_pkg::CHAR_N, esd_pkg::CHAR_ZERO, esd_pkg::CHAR_T,
            esd_pkg::CHAR_BACKSLASH, esd_pkg::CHAR_B, esd_pkg::CHAR_O,
            esd_pkg::CHAR_D, esd_pkg::CHAR_X: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic put_dec(input logic [7:0] c, input logic l);
        esd_pkg::out_item_t r;
        r.out_char = c;
        r.out_last = l;
        expected_dec.push_back(r);
    endtask

    // A numeric escape that failed goes out literally, digits included.
    task automatic replay_held();
        put_dec(esd_pkg::CHAR_BACKSLASH, 1'b0);
        put_dec(kind_letter(num_kind), 1'b0);
        for (int k = 0; k < int'(held_n); k++)
            put_dec(held_chars[k], 1'b0);
        held_n    = '0;
        acc_value = '0;
        esc_state = ST_IDLE;
    endtask

    task automatic plain_char(input logic [7:0] c, input logic l);
        esc_state = ST_IDLE;
        if (c == esd_pkg::CHAR_BACKSLASH && !l)
        begin
            esc_state = ST_SLASH;
        end
        else
        begin
            put_dec(c, 1'b0);
            if (l)
                put_dec(esd_pkg::CODE_NUL, 1'b1);
        end
    endtask

    // Works out the decoded characters caused by one accepted request.
    task automatic decode_char(input esd_pkg::in_item_t item);
        logic [7:0] c;
        logic       l;
        int         d;
        int         nxt;
        c = item.in_char;
        l = item.in_last;
        case (esc_state)
            ST_SLASH:
            begin
                esc_state = ST_IDLE;
                case (c)
                    esd_pkg::CHAR_R:         put_dec(esd_pkg::CODE_CR, 1'b0);
                    esd_pkg::CHAR_N:         put_dec(esd_pkg::CODE_LF, 1'b0);
                    esd_pkg::CHAR_ZERO:      put_dec(esd_pkg::CODE_NUL, 1'b0);
                    esd_pkg::CHAR_T:         put_dec(esd_pkg::CODE_TAB, 1'b0);
                    esd_pkg::CHAR_BACKSLASH: put_dec(esd_pkg::CHAR_BACKSLASH, 1'b0);
                    esd_pkg::CHAR_B, esd_pkg::CHAR_O, esd_pkg::CHAR_D, esd_pkg::CHAR_X:
                    begin
                        if (l)
                        begin
                            put_dec(esd_pkg::CHAR_BACKSLASH, 1'b0);
                            put_dec(c, 1'b0);
                        end
                        else
                        begin
                            num_kind  = letter_kind(c);
                            held_n    = '0;
                            acc_value = '0;
                            esc_state = ST_DIGITS;
                        end
                    end
                    default:
                    begin
                        put_dec(esd_pkg::CHAR_BACKSLASH, 1'b0);
                        put_dec(c, 1'b0);
                    end
                endcase
                if (l)
                    put_dec(esd_pkg::CODE_NUL, 1'b1);
            end
            ST_DIGITS:
            begin
                d   = digit_val(c, radix(num_kind));
                nxt = int'(acc_value) * radix(num_kind) + d;
                if (d < 0)
                begin
                    replay_held();
                    plain_char(c, l);
                end
                else if (int'(held_n) + 1 >= ndigits(num_kind))
                begin
                    // Last digit: the value wraps to one byte.
                    put_dec(nxt[7:0], 1'b0);
                    held_n    = '0;
                    acc_value = '0;
                    esc_state = ST_IDLE;
                    if (l)
                        put_dec(esd_pkg::CODE_NUL, 1'b1);
                end
                else
                begin
                    held_chars[held_n] = c;
                    held_n    = held_n + 3'd1;
                    acc_value = nxt[9:0];
                    if (l)
                    begin
                        replay_held();
                        put_dec(esd_pkg::CODE_NUL, 1'b1);
                    end
                end
            end
            default: plain_char(c, l);
        endcase
    endtask

    task automatic report(input string what, input int got, input int want);
        err_cnt++;
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    endtask

    // Text building: characters collect in text_buf, then go out as one text.
    task automatic buf_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic flush_text();
        esd_pkg::in_item_t item;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            item.in_char = text_buf[i];
            item.in_last = (i == text_buf.size() - 1);
            pending_text.push_back(item);
            queued_cnt++;
        end
        text_buf.delete();
    endtask

    function automatic logic [7:0] rand_digit(input num_kind_t k);
        int v;
        v = int'($urandom_range(radix(k) - 1, 0));
        if (v < 10)
            return esd_pkg::CHAR_ZERO + v[7:0];
        if ($urandom_range(1, 0) == 0)
            return CHAR_LO_A + v[7:0] - 8'd10;
        return CHAR_UP_A + v[7:0] - 8'd10;
    endfunction

    function automatic logic [7:0] bad_digit(input num_kind_t k);
        logic [7:0] c;
        if ($urandom_range(3, 0) == 0)
            return esd_pkg::CHAR_BACKSLASH;
        c = 8'($urandom_range(255, 0));
        while (digit_val(c, radix(k)) >= 0)
            c = 8'($urandom_range(255, 0));
        return c;
    endfunction

    // One piece of a text; the truncated forms only close a text.
    task automatic add_token(input bit at_end);
        int         sel;
        int         cnt;
        num_kind_t  k;
        logic [7:0] c;
        sel = int'($urandom_range(at_end ? 7 : 5, 0));
        k   = num_kind_t'($urandom_range(3, 0));
        case (sel)
            0, 1: text_buf.push_back(8'($urandom_range(255, 0)));
            2:
            begin
                text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
                case ($urandom_range(4, 0))
                    0:       text_buf.push_back(esd_pkg::CHAR_R);
                    1:       text_buf.push_back(esd_pkg::CHAR_N);
                    2:       text_buf.push_back(esd_pkg::CHAR_ZERO);
                    3:       text_buf.push_back(esd_pkg::CHAR_T);
                    default: text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
                endcase
            end
            3:
            begin
                text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
                text_buf.push_back(kind_letter(k));
                repeat (ndigits(k))
                    text_buf.push_back(rand_digit(k));
            end
            4:
            begin
                text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
                text_buf.push_back(kind_letter(k));
                cnt = int'($urandom_range(ndigits(k) - 1, 0));
                repeat (cnt)
                    text_buf.push_back(rand_digit(k));
                text_buf.push_back(bad_digit(k));
            end
            5:
            begin
                c = 8'($urandom_range(255, 0));
                while (is_escape_letter(c))
                    c = 8'($urandom_range(255, 0));
                text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
                text_buf.push_back(c);
            end
            6:
            begin
                text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
                text_buf.push_back(kind_letter(k));
                cnt = int'($urandom_range(ndigits(k) - 1, 0));
                repeat (cnt)
                    text_buf.push_back(rand_digit(k));
            end
            default: text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
        endcase
    endtask

    // Random texts: mostly well-formed escapes, some raw byte noise.
    task automatic queue_random(input int n_items);
        int start;
        int ntok;
        start = queued_cnt;
        while (queued_cnt - start < n_items)
        begin
            if ($urandom_range(99, 0) < 15)
            begin
                repeat ($urandom_range(6, 1))
                    text_buf.push_back(8'($urandom_range(255, 0)));
            end
            else
            begin
                ntok = int'($urandom_range(5, 1));
                for (int i = 0; i < ntok; i++)
                    add_token(i == ntok - 1);
            end
            flush_text();
        end
    endtask

    // Waits at falling edges until every request is sent and decoded.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_text.size() != 0 || text_valid || expected_dec.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        sender_idle_pct = tx_pct;
        recv_stall_pct  = rx_pct;
    endtask

    // Sender: offers the next request and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text       <= '0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                decode_char(text);
                accepted_cnt++;
            end
            if (!text_valid || text_ready)
            begin
                if (pending_text.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    text_valid <= 1'b1;
                    text       <= pending_text.pop_front();
                end
                else
                begin
                    text_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each decoded character against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_ready <= 1'b0;
        end
        else
        begin
            if (dec_valid && dec_ready)
            begin
                checked_cnt++;
                if (expected_dec.size() == 0)
                begin
                    report("unexpected out_char", int'(dec.out_char), 0);
                end
                else
                begin
                    if (dec.out_char !== expected_dec[0].out_char)
                        report("out_char", int'(dec.out_char),
                               int'(expected_dec[0].out_char));
                    if (dec.out_last !== expected_dec[0].out_last)
                        report("out_last", int'(dec.out_last),
                               int'(expected_dec[0].out_last));
                    void'(expected_dec.pop_front());
                end
            end
            dec_ready <= (hold_left == 0) && !hold_start
                         && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still due",
                     cycle_cnt, expected_dec.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every simple escape, wrapping decimal, unknown escape with
        // the top byte, a plain NUL, a bad hex digit on the final character.
        set_idle(0, 0);
        buf_str("\\r\\n\\0\\t\\\\\\d999");
        text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        buf_str("\\xG");
        flush_text();
        // Text ends inside the digits.
        buf_str("\\o1");
        flush_text();
        // Backslash as the final character.
        text_buf.push_back(esd_pkg::CHAR_BACKSLASH);
        flush_text();
        // Numeric letter as the final character.
        buf_str("\\b");
        flush_text();
        wait_drained();

        // Back-pressure: the receiver holds off while requests keep coming.
        hold_start = 1'b1;
        queue_random(20);
        @(negedge clk);
        hold_start = 1'b0;
        wait_drained();

        // Random texts under each idle mix.
        set_idle(0, 0);
        queue_random(22);
        wait_drained();
        set_idle(84, 0);
        queue_random(22);
        wait_drained();
        set_idle(0, 84);
        queue_random(22);
        wait_drained();
        set_idle(24, 24);
        queue_random(22);
        wait_drained();

        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Sent %0d text requests and checked %0d decoded characters", accepted_cnt,
                 checked_cnt);
        $display("Phases: directed escapes, long receiver hold, four idle mixes");
        if (err_cnt == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", err_cnt);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
